[rtl/qrs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

    localparam int COEF_WIDTH = 16;
    localparam int ROOT_WIDTH = 48;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_ONE  = 2'd1;
    localparam logic [1:0] KIND_TWO  = 2'd2;
    localparam logic [1:0] KIND_ALL  = 2'd3;

    typedef logic signed [COEF_WIDTH-1:0] coef_t;
    typedef logic signed [ROOT_WIDTH-1:0] root_t;

    typedef struct packed {
        coef_t coef_a;
        coef_t coef_b;
        coef_t coef_c;
    } qrs_in_t;

    typedef struct packed {
        logic [1:0] solution_kind;
        root_t      first_root;
        root_t      second_root;
    } qrs_out_t;

    // carried alongside the square root chain
    typedef struct packed {
        logic [1:0] kind;
        coef_t      a;
        coef_t      b;
        coef_t      c;
    } qrs_side_t;

    // carried alongside the divider chain
    typedef struct packed {
        logic [1:0] kind;
        logic       neg1;
        logic       neg2;
    } qrs_dside_t;

endpackage

`default_nettype wire

[rtl/qrs_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One restoring square root step: brings in the next radicand bit pair,
// produces one root bit.
module qrs_sqrt_cell #(
    parameter int SW  = 33,
    parameter int RDW = 34,
    parameter int SBW = 50
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic [RDW-1:0] in_rad,
    input  wire logic [SW-1:0]  in_rem,
    input  wire logic [SW-1:0]  in_root,
    input  wire logic [SBW-1:0] in_side,
    output logic                out_valid,
    output logic [RDW-1:0]      out_rad,
    output logic [SW-1:0]       out_rem,
    output logic [SW-1:0]       out_root,
    output logic [SBW-1:0]      out_side
);

    logic           valid_reg;
    logic [RDW-1:0] rad_reg, rad_next;
    logic [SW-1:0]  rem_reg, rem_next;
    logic [SW-1:0]  root_reg, root_next;
    logic [SBW-1:0] side_reg;
    logic [SW+1:0]  rem_sh, trial, diff;
    logic           ge;

    always_comb begin
        rem_sh    = {in_rem, in_rad[RDW-1 -: 2]};
        trial     = {in_root, 2'b01};
        ge        = rem_sh >= trial;
        diff      = rem_sh - trial;
        // remainder stays below 2^SW on every step whose result is used
        rem_next  = ge ? diff[SW-1:0] : rem_sh[SW-1:0];
        root_next = {in_root[SW-2:0], ge};
        rad_next  = {in_rad[RDW-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

[rtl/qrs_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One restoring division step on two lanes sharing a divisor.
// Numerator bits shift out at the top, quotient bits shift in at the bottom.
module qrs_div_cell #(
    parameter int NW  = 34,
    parameter int DVW = 17,
    parameter int SBW = 4
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire logic [1:0][NW-1:0]       in_nq,
    input  wire logic [1:0][DVW-1:0]      in_rem,
    input  wire logic [DVW-1:0]           in_den,
    input  wire logic [SBW-1:0]           in_side,
    output logic                          out_valid,
    output logic [1:0][NW-1:0]            out_nq,
    output logic [1:0][DVW-1:0]           out_rem,
    output logic [DVW-1:0]                out_den,
    output logic [SBW-1:0]                out_side
);

    logic                valid_reg;
    logic [1:0][NW-1:0]  nq_reg, nq_next;
    logic [1:0][DVW-1:0] rem_reg, rem_next;
    logic [DVW-1:0]      den_reg;
    logic [SBW-1:0]      side_reg;
    logic [1:0][DVW:0]   rs, diff;
    logic [1:0]          ge;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            rs[i]       = {in_rem[i], in_nq[i][NW-1]};
            ge[i]       = rs[i] >= {1'b0, in_den};
            diff[i]     = rs[i] - {1'b0, in_den};
            rem_next[i] = ge[i] ? diff[i][DVW-1:0] : rs[i][DVW-1:0];
            nq_next[i]  = {in_nq[i][NW-2:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nq_reg   <= nq_next;
            rem_reg  <= rem_next;
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_nq    = nq_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

[rtl/quadratic_root_solver_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel | Ports                     | Payload
// --------+---------------------------+-------------------------------------
// input   | s_valid, s_ready, s_data  | qrs_in_t: coef_a, coef_b, coef_c
// result  | m_valid, m_ready, m_data  | qrs_out_t: kind, first/second root
//
// One transfer in per cycle while no result is held, one result per transfer, in order.
// The pipeline holds SW = COEF_WIDTH+1+FRAC_BITS square root cells and
// NW = COEF_WIDTH+FRAC_BITS+2 divider cells between its registered stages.
// A held result on m_data stalls the whole pipeline; s_ready is low only then.
// aresetn clears the valid bits of every stage.
module quadratic_root_solver_top
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire qrs_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output qrs_out_t      m_data
);

    localparam int CW  = COEF_WIDTH;
    localparam int DSW = 2 * CW + 3;
    localparam int RDW = 2 * CW + 2;
    localparam int SW  = CW + 1 + FRAC_BITS;
    localparam int NW  = CW + FRAC_BITS + 2;
    localparam int DVW = CW + 1;
    localparam int QW  = NW + ROOT_WIDTH + 1;
    localparam int SBS = $bits(qrs_side_t);
    localparam int SBD = $bits(qrs_dside_t);

    localparam logic signed [QW-1:0] RMAX = QW'({1'b0, {(ROOT_WIDTH-1){1'b1}}});
    localparam logic signed [QW-1:0] RMIN = -RMAX - QW'(1);

    logic adv;

    // stage 0: input register
    logic    v0_reg;
    qrs_in_t in_reg;

    // stage 1: products
    logic                   v1_reg;
    logic signed [2*CW-1:0] bb_reg, ac_reg, bb_next, ac_next, bx, ax, cx;
    coef_t                  a1_reg, b1_reg, c1_reg;

    // stage 2: discriminant and case
    logic signed [DSW-1:0] disc;
    logic [1:0]            kind2;
    logic [RDW-1:0]        rad2;
    logic                  v2_reg;
    logic [RDW-1:0]        rad2_reg;
    qrs_side_t             side2_reg;

    // square root chain
    logic                 sq_v    [SW+1];
    logic [RDW-1:0]       sq_rad  [SW+1];
    logic [SW-1:0]        sq_rem  [SW+1];
    logic [SW-1:0]        sq_root [SW+1];
    logic [SBS-1:0]       sq_side [SW+1];

    // divider setup
    qrs_side_t             ps;
    logic signed [NW:0]    nb, nc, sx, num1, num2, mag1, mag2;
    logic signed [DVW-1:0] den, dmag;
    qrs_dside_t            dside_next;
    logic                  v3_reg;
    logic [1:0][NW-1:0]    nq3_reg;
    logic [DVW-1:0]        den3_reg;
    qrs_dside_t            dside3_reg;

    // divider chain
    logic                 dv_v    [NW+1];
    logic [1:0][NW-1:0]   dv_nq   [NW+1];
    logic [1:0][DVW-1:0]  dv_rem  [NW+1];
    logic [DVW-1:0]       dv_den  [NW+1];
    logic [SBD-1:0]       dv_side [NW+1];

    // output
    qrs_dside_t         fs;
    logic signed [QW-1:0] q1, q2;
    root_t              r1, r2;
    qrs_out_t           out_next, out_reg;
    logic               m_valid_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v0_reg      <= s_valid;
            v1_reg      <= v0_reg;
            v2_reg      <= v1_reg;
            v3_reg      <= sq_v[SW];
            m_valid_reg <= dv_v[NW];
        end
    end

    always_comb begin
        ax      = (2*CW)'(in_reg.coef_a);
        bx      = (2*CW)'(in_reg.coef_b);
        cx      = (2*CW)'(in_reg.coef_c);
        bb_next = bx * bx;
        ac_next = ax * cx;
    end

    always_comb begin
        disc  = DSW'(bb_reg) - (DSW'(ac_reg) <<< 2);
        rad2  = '0;
        if (a1_reg == '0) begin
            if (b1_reg == '0) begin
                kind2 = (c1_reg == '0) ? KIND_ALL : KIND_NONE;
            end else begin
                kind2 = KIND_ONE;
            end
        end else if (disc < 0) begin
            kind2 = KIND_NONE;
        end else if (disc == '0) begin
            kind2 = KIND_ONE;
        end else begin
            kind2 = KIND_TWO;
            rad2  = disc[RDW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg         <= s_data;
            bb_reg         <= bb_next;
            ac_reg         <= ac_next;
            a1_reg         <= in_reg.coef_a;
            b1_reg         <= in_reg.coef_b;
            c1_reg         <= in_reg.coef_c;
            rad2_reg       <= rad2;
            side2_reg.kind <= kind2;
            side2_reg.a    <= a1_reg;
            side2_reg.b    <= b1_reg;
            side2_reg.c    <= c1_reg;
        end
    end

    assign sq_v[0]    = v2_reg;
    assign sq_rad[0]  = rad2_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = side2_reg;

    for (genvar g = 0; g < SW; g++) begin : g_sqrt
        qrs_sqrt_cell #(
            .SW  (SW),
            .RDW (RDW),
            .SBW (SBS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (sq_v[g]),
            .in_rad    (sq_rad[g]),
            .in_rem    (sq_rem[g]),
            .in_root   (sq_root[g]),
            .in_side   (sq_side[g]),
            .out_valid (sq_v[g+1]),
            .out_rad   (sq_rad[g+1]),
            .out_rem   (sq_rem[g+1]),
            .out_root  (sq_root[g+1]),
            .out_side  (sq_side[g+1])
        );
    end

    always_comb begin
        ps = qrs_side_t'(sq_side[SW]);
        nb = -((NW+1)'(ps.b) <<< FRAC_BITS);
        nc = -((NW+1)'(ps.c) <<< FRAC_BITS);
        sx = (NW+1)'(sq_root[SW]);
        if (ps.a == '0) begin
            num1 = nc;
            num2 = nc;
            den  = DVW'(ps.b);
        end else begin
            den = {ps.a, 1'b0};
            if (ps.kind == KIND_TWO) begin
                num1 = nb + sx;
                num2 = nb - sx;
            end else begin
                num1 = nb;
                num2 = nb;
            end
        end
        mag1            = num1[NW] ? -num1 : num1;
        mag2            = num2[NW] ? -num2 : num2;
        dmag            = den[DVW-1] ? -den : den;
        dside_next.kind = ps.kind;
        dside_next.neg1 = num1[NW] ^ den[DVW-1];
        dside_next.neg2 = num2[NW] ^ den[DVW-1];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nq3_reg[0] <= mag1[NW-1:0];
            nq3_reg[1] <= mag2[NW-1:0];
            den3_reg   <= dmag;
            dside3_reg <= dside_next;
        end
    end

    assign dv_v[0]    = v3_reg;
    assign dv_nq[0]   = nq3_reg;
    assign dv_rem[0]  = '0;
    assign dv_den[0]  = den3_reg;
    assign dv_side[0] = dside3_reg;

    for (genvar g = 0; g < NW; g++) begin : g_div
        qrs_div_cell #(
            .NW  (NW),
            .DVW (DVW),
            .SBW (SBD)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (dv_v[g]),
            .in_nq     (dv_nq[g]),
            .in_rem    (dv_rem[g]),
            .in_den    (dv_den[g]),
            .in_side   (dv_side[g]),
            .out_valid (dv_v[g+1]),
            .out_nq    (dv_nq[g+1]),
            .out_rem   (dv_rem[g+1]),
            .out_den   (dv_den[g+1]),
            .out_side  (dv_side[g+1])
        );
    end

    always_comb begin
        fs = qrs_dside_t'(dv_side[NW]);
        q1 = fs.neg1 ? -QW'(dv_nq[NW][0]) : QW'(dv_nq[NW][0]);
        q2 = fs.neg2 ? -QW'(dv_nq[NW][1]) : QW'(dv_nq[NW][1]);
        r1 = (q1 > RMAX) ? RMAX[ROOT_WIDTH-1:0] :
             (q1 < RMIN) ? RMIN[ROOT_WIDTH-1:0] : q1[ROOT_WIDTH-1:0];
        r2 = (q2 > RMAX) ? RMAX[ROOT_WIDTH-1:0] :
             (q2 < RMIN) ? RMIN[ROOT_WIDTH-1:0] : q2[ROOT_WIDTH-1:0];
        out_next.solution_kind = fs.kind;
        if (fs.kind == KIND_NONE || fs.kind == KIND_ALL) begin
            out_next.first_root  = '0;
            out_next.second_root = '0;
        end else begin
            out_next.first_root  = r1;
            out_next.second_root = r2;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_unused_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.solution_kind == KIND_NONE || m_data.solution_kind == KIND_ALL)
        |-> m_data.first_root == '0 && m_data.second_root == '0)
        else $error("unused roots not zero");

    a_single_equal : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.solution_kind == KIND_ONE |-> m_data.first_root == m_data.second_root)
        else $error("single root differs between lanes");

    a_reset_idle : assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(dv_nq[NW]) && $stable(sq_root[SW]))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

[tb/quadratic_root_solver_top_tb.sv]
`timescale 1ns / 1ps

module quadratic_root_solver_top_tb;
    import qrs_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 72;
    localparam longint CYCLE_LIMIT = 400000;

    class root_scoreboard;
        qrs_out_t pending_roots[$];
        int errors;
        int checked;

        function new();
            errors = 0;
            checked = 0;
        endfunction

        // trunc-toward-zero division on 64-bit signed values
        function longint tdiv(longint n, longint d);
            longint q;
            q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
            return ((n < 0) != (d < 0)) ? -q : q;
        endfunction

        function logic [ROOT_WIDTH-1:0] sat_root(longint r);
            longint hi, lo;
            hi = (longint'(1) <<< (ROOT_WIDTH - 1)) - 1;
            lo = -hi - 1;
            if (r > hi) r = hi;
            if (r < lo) r = lo;
            return r[ROOT_WIDTH-1:0];
        endfunction

        // floor(sqrt(d * 4^FRAC)), bit-serial over a 128-bit radicand
        function longint scaled_sqrt(logic [127:0] disc);
            logic [127:0] rad, rem, root, trial;
            rad = disc << (2 * FRAC);
            rem = 0;
            root = 0;
            for (int k = 63; k >= 0; k--) begin
                rem = (rem << 2) | ((rad >> (2 * k)) & 128'd3);
                trial = (root << 2) | 128'd1;
                root = root << 1;
                if (rem >= trial) begin
                    rem = rem - trial;
                    root = root | 128'd1;
                end
            end
            return longint'(root[63:0]);
        endfunction

        function void note_equation(qrs_in_t eq);
            longint a, b, c, one, s, r1, r2;
            logic signed [127:0] disc;
            logic [1:0] kind;
            a = eq.coef_a;
            b = eq.coef_b;
            c = eq.coef_c;
            one = longint'(1) <<< FRAC;
            r1 = 0;
            r2 = 0;
            if (a == 0) begin
                if (b == 0) begin
                    kind = (c == 0) ? KIND_ALL : KIND_NONE;
                end else begin
                    kind = KIND_ONE;
                    r1 = tdiv(-c * one, b);
                    r2 = r1;
                end
            end else begin
                disc = 128'(b * b) - 128'(4 * a * c);
                if (disc < 0) begin
                    kind = KIND_NONE;
                end else if (disc == 0) begin
                    kind = KIND_ONE;
                    r1 = tdiv(-b * one, 2 * a);
                    r2 = r1;
                end else begin
                    kind = KIND_TWO;
                    s = scaled_sqrt(disc);
                    r1 = tdiv(-b * one + s, 2 * a);
                    r2 = tdiv(-b * one - s, 2 * a);
                end
            end
            pending_roots.push_back({kind, sat_root(r1), sat_root(r2)});
        endfunction

        function void check_roots(qrs_out_t got);
            qrs_out_t want;
            if (pending_roots.size() == 0) begin
                $error("result with nothing pending: %h", got);
                errors++;
                return;
            end
            want = pending_roots.pop_front();
            checked++;
            if (got.solution_kind !== want.solution_kind) begin
                $error("solution_kind expected %0d got %0d",
                       want.solution_kind, got.solution_kind);
                errors++;
            end
            if (got.first_root !== want.first_root) begin
                $error("first_root expected %0d got %0d",
                       want.first_root, got.first_root);
                errors++;
            end
            if (got.second_root !== want.second_root) begin
                $error("second_root expected %0d got %0d",
                       want.second_root, got.second_root);
                errors++;
            end
        endfunction
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    qrs_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    qrs_out_t m_data;

    root_scoreboard sb;
    longint cycle_count;
    bit     stim_done;
    int     sent;

    quadratic_root_solver_top #(.FRAC_BITS(FRAC)) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic coef_t rand_coef();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return coef_t'(0);
            3, 4: return coef_t'(int'($urandom_range(0, 20)) - 10);
            default: return coef_t'($urandom());
        endcase
    endfunction

    // perfect-square style roots: a*(x-p)*(x-q) with small p, q
    function automatic qrs_in_t factored_eq();
        qrs_in_t eq;
        int a, p, q;
        a = $urandom_range(1, 8) * ($urandom_range(0, 1) ? 1 : -1);
        p = $urandom_range(0, 20) - 10;
        q = ($urandom_range(0, 3) == 0) ? p : $urandom_range(0, 20) - 10;
        eq.coef_a = coef_t'(a);
        eq.coef_b = coef_t'(-a * (p + q));
        eq.coef_c = coef_t'(a * p * q);
        return eq;
    endfunction

    // valid stays up after the transfer; idle_input drops it when a gap follows
    task automatic send_equation(qrs_in_t eq);
        s_valid <= 1'b1;
        s_data  <= eq;
        do @(posedge aclk); while (!s_ready);
        sb.note_equation(eq);
        sent++;
        @(negedge aclk);
    endtask

    task automatic idle_input();
        int n;
        n = gap_len();
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    initial begin
        qrs_in_t eq;
        qrs_in_t directed[$];
        sb = new();
        s_valid = 1'b0;
        s_data = '0;
        aresetn = 1'b0;
        stim_done = 0;
        sent = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        directed.push_back('{16'sd0, 16'sd0, 16'sd0});      // every x
        directed.push_back('{16'sd0, 16'sd0, 16'sd5});      // no solution, degenerate
        directed.push_back('{16'sd0, 16'sd3, -16'sd7});     // linear
        directed.push_back('{16'sd0, 16'sh8000, 16'sh7fff});
        directed.push_back('{16'sd0, -16'sd1, 16'sh8000});
        directed.push_back('{16'sd1, -16'sd2, 16'sd1});     // double root
        directed.push_back('{16'sd1, 16'sd0, -16'sd4});
        directed.push_back('{16'sd1, 16'sd0, 16'sd1});      // negative discriminant
        directed.push_back('{16'sd2, 16'sd3, -16'sd5});
        directed.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff});
        directed.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
        directed.push_back('{16'sh8000, 16'sh7fff, 16'sh7fff});
        directed.push_back('{16'sh7fff, 16'sh8000, 16'sh8000});
        directed.push_back('{16'sh8000, 16'sh8000, 16'sh7fff});
        directed.push_back('{16'sd1, 16'sh8000, 16'sd0});
        directed.push_back('{-16'sd1, 16'sd0, 16'sd0});
        directed.push_back('{16'sh8000, 16'sd0, 16'sh8000});
        directed.push_back('{-16'sd3, 16'sd7, 16'sd11});
        directed.push_back('{16'shffff, 16'shffff, 16'shffff});
        foreach (directed[i]) begin
            send_equation(directed[i]);
            if (i % 5 == 4) idle_input();
        end

        for (int n = 0; n < 1450; n++) begin
            if ($urandom_range(0, 2) == 0) begin
                eq = factored_eq();
            end else begin
                eq.coef_a = ($urandom_range(0, 9) == 0) ? coef_t'(0) : rand_coef();
                eq.coef_b = rand_coef();
                eq.coef_c = rand_coef();
            end
            send_equation(eq);
            if (n > 200 && n < 400) continue;  // back-to-back stretch
            idle_input();
        end
        s_valid <= 1'b0;
        stim_done = 1;
    end

    // result side: random backpressure, sampled at the rising edge
    initial begin
        int hold;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0 && !(cycle_count > 8000 && cycle_count < 12000))
                    hold = gap_len();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_roots(m_data);
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        wait (stim_done);
        while (sb.pending_roots.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("sent %0d equations, checked %0d results over %0d cycles",
                 sent, sb.checked, cycle_count);
        if (sb.errors == 0 && sb.pending_roots.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
